// ===== rtl/core/sads_pkg.sv =====
// Shared types, codes and constants of the two-stacks-in-one-array block.
package sads_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int VALUE_W     = 32;
    localparam int SIZE_W      = 9;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 56;
    localparam int M_PAD_W     = M_TDATA_W - (VALUE_W + STATUS_W + 2 * SIZE_W + 1);
    localparam int EXT_W       = 64;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } sts_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;      // carry out the transaction on the input channel
        logic load_out;  // move the finished result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register empty or being drained this cycle
    } stat_t;

endpackage

// ===== rtl/core/sads_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
module sads_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sads_ctrl.sv =====
// Control state machine: accept one transaction, then hand its result to the output.
module sads_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sads_pkg::stat_t     stat,
    output sads_pkg::cmd_t      cmd
);

    typedef enum logic {
        S_IDLE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next   = state_reg;
        ready_next   = ready_reg;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.exec = s_tvalid && ready_reg;
                if (s_tvalid && ready_reg) begin
                    state_next = S_FINISH;
                    ready_next = 1'b0;
                end
            end
            S_FINISH: begin
                // read data is in the RAM output register now
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                    ready_next   = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

// ===== rtl/core/sads_datapath.sv =====
// Datapath: stack counters, store address and access, output register.
module sads_datapath #(
    parameter int DEPTH      = sads_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = sads_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sads_pkg::cmd_t                      cmd,
    output sads_pkg::stat_t                     stat,
    input  logic [sads_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [sads_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                ram_wr_en,
    output logic                                ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]            ram_addr,
    output logic [DATA_WIDTH-1:0]               ram_wr_data,
    input  logic [DATA_WIDTH-1:0]               ram_rd_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sads_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] TOP_IDX = CNT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_N = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [CNT_W-1:0] count_one_reg, count_one_next;
    logic [CNT_W-1:0] count_two_reg, count_two_next;
    sads_pkg::sts_t   sts_reg, sts_next;
    logic             hit_reg, hit_next;
    logic             out_valid_reg, out_valid_next;
    logic [sads_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    sads_pkg::op_t    op;
    logic             sel;
    logic [CNT_W:0]   total;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] addr_full;
    logic [sads_pkg::EXT_W-1:0] push_ext;
    logic [sads_pkg::EXT_W-1:0] rd_ext;
    logic [31:0]      one_ext;
    logic [31:0]      two_ext;
    logic [sads_pkg::VALUE_W-1:0] read_value;

    assign op    = sads_pkg::op_t'(s_tuser[1:0]);
    assign sel   = s_tuser[2];
    assign total = {1'b0, count_one_reg} + {1'b0, count_two_reg};
    assign full  = (total == DEPTH_S);
    assign empty = sel ? (count_two_reg == '0) : (count_one_reg == '0);

    assign push_ext    = sads_pkg::EXT_W'(s_tdata);
    assign ram_wr_data = push_ext[DATA_WIDTH-1:0];
    assign ram_addr    = addr_full[AW-1:0];

    always_comb begin
        count_one_next = count_one_reg;
        count_two_next = count_two_reg;
        sts_next       = sts_reg;
        hit_next       = hit_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        addr_full      = count_one_reg;
        if (cmd.exec) begin
            sts_next = sads_pkg::ST_DONE;
            hit_next = 1'b0;
            unique case (op)
                sads_pkg::OP_PUSH: begin
                    if (full) begin
                        sts_next = sads_pkg::ST_FULL;
                    end else if (sel) begin
                        ram_wr_en      = 1'b1;
                        addr_full      = TOP_IDX - count_two_reg;
                        count_two_next = count_two_reg + CNT_ONE;
                    end else begin
                        ram_wr_en      = 1'b1;
                        addr_full      = count_one_reg;
                        count_one_next = count_one_reg + CNT_ONE;
                    end
                end
                sads_pkg::OP_POP, sads_pkg::OP_PEEK: begin
                    if (empty) begin
                        sts_next = sads_pkg::ST_EMPTY;
                    end else begin
                        ram_rd_en = 1'b1;
                        hit_next  = 1'b1;
                        addr_full = sel ? (DEPTH_N - count_two_reg)
                                        : (count_one_reg - CNT_ONE);
                        if (op == sads_pkg::OP_POP) begin
                            if (sel) begin
                                count_two_next = count_two_reg - CNT_ONE;
                            end else begin
                                count_one_next = count_one_reg - CNT_ONE;
                            end
                        end
                    end
                end
                sads_pkg::OP_CLEAR: begin
                    if (sel) begin
                        count_two_next = '0;
                    end else begin
                        count_one_next = '0;
                    end
                end
                default: begin
                    sts_next = sads_pkg::ST_DONE;
                end
            endcase
        end
    end

    // result fields, taken once counts already reflect the operation
    assign rd_ext     = sads_pkg::EXT_W'(ram_rd_data);
    assign read_value = hit_reg ? rd_ext[sads_pkg::VALUE_W-1:0] : '0;
    assign one_ext    = 32'(count_one_reg);
    assign two_ext    = 32'(count_two_reg);

    assign stat.out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = {{sads_pkg::M_PAD_W{1'b0}}, full,
                              two_ext[sads_pkg::SIZE_W-1:0],
                              one_ext[sads_pkg::SIZE_W-1:0],
                              sts_reg, read_value};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_one_reg <= '0;
            count_two_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_one_reg <= count_one_next;
            count_two_reg <= count_two_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sts_reg      <= sts_next;
        hit_reg      <= hit_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/shared_array_double_stack_top.sv =====
// Top level: two LIFO stacks sharing one store, stream in and stream out.
//
// Usage:
//   Input channel (s_*): one transaction is one operation. s_tuser[1:0] is
//   the operation (push, pop, peek, clear), s_tuser[2] selects the stack
//   (0 grows up from entry 0, 1 grows down from entry DEPTH-1), s_tdata
//   carries the word for a push.
//   Output channel (m_*): exactly one result transaction per operation, in
//   order: read value, status, both stack sizes and the store-full flag.
//   Timing: the counters and the registered store read update at the
//   accepting edge, and the output register loads once it is free.
//   s_tready is low from the accept until the result loads, so a new
//   operation waits until the last result has moved to the output register.
//   Stalls: the result sits in the output register while m_tready is low;
//   the next operation is still accepted and carried out, and its result
//   waits in the datapath, with s_tready low, until the output register frees.
//   Reset: aresetn low empties both stacks and drops m_tvalid; the store
//   is not cleared, as no word is read before it was pushed. A refused
//   push (store full) or pop/peek (stack empty) gives a status code, a
//   zero read value and no change of state.
module shared_array_double_stack_top #(
    parameter int DEPTH      = sads_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = sads_pkg::DATA_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] push_value
    input  logic [sads_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind, [2] which_stack
    input  logic [sads_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] read_value, [33:32] status, [42:34] stack_one_size,
    // [51:43] stack_two_size, [52] store_full, [55:53] zero
    output logic [sads_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(DEPTH);

    sads_pkg::cmd_t  cmd;
    sads_pkg::stat_t stat;

    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    sads_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sads_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .ram_wr_en   (ram_wr_en),
        .ram_rd_en   (ram_rd_en),
        .ram_addr    (ram_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_data (ram_rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // shared store: both stacks live here
    sads_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== rtl/core/sads_checker.sv =====
// Port-level checker for the two-stacks block, bound to the top level.
module sads_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [sads_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one operation at a time: no input right after an accepted one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back-to-back cycles");

    // status is a defined code, and a refused operation reads zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:32] == sads_pkg::ST_DONE || m_tdata[31:0] == 32'd0)
                     && (m_tdata[33:32] == sads_pkg::ST_DONE
                         || m_tdata[33:32] == sads_pkg::ST_FULL
                         || m_tdata[33:32] == sads_pkg::ST_EMPTY))
        else $error("bad status or nonzero read on refused operation");

    // a full store never shows both stacks empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[52] |-> m_tdata[42:34] != 9'd0 || m_tdata[51:43] != 9'd0)
        else $error("store full with both stacks empty");

    // reset drops the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind shared_array_double_stack_top sads_checker u_sads_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the two-stacks-in-one-array block (stream in, stream out).
`timescale 1ns / 1ps

module tb_top;
    import sads_pkg::*;

    localparam int STORE_DEPTH  = DEPTH_DEF;
    localparam int RUN_LIMIT    = 400_000;  // cycles
    localparam int DRAIN_CYCLES = 8;        // cycles of slack after the last result
    localparam int HOLD_CYCLES  = 300;      // long output stall, forces input backpressure
    localparam int HOLD_AFTER   = 100;      // start the long stall after this many ops
    localparam int QUIET_TAIL   = 150;      // last ops run with no idling on either side

    // Expected fields of one output transaction
    typedef struct {
        logic [VALUE_W-1:0] read_value;
        sts_t               status;
        logic [SIZE_W-1:0]  one_size;
        logic [SIZE_W-1:0]  two_size;
        logic               full;
    } stack_result_t;

    // Tracks both stacks and the shared store, predicts each result in order
    class stack_pair_scoreboard;
        logic [VALUE_W-1:0] words [STORE_DEPTH];
        int                 size_one;
        int                 size_two;
        stack_result_t      pending_results [$];
        int                 mismatches;

        function new();
            size_one   = 0;
            size_two   = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted op to the shadow stacks and queue its result
        function void note_op(op_t op, bit sel, logic [VALUE_W-1:0] val);
            stack_result_t r;
            int            idx;
            int            cnt;
            r.read_value = '0;
            r.status     = ST_DONE;
            case (op)
                OP_PUSH: begin
                    if (size_one + size_two >= STORE_DEPTH) begin
                        r.status = ST_FULL;
                    end else if (!sel) begin
                        words[size_one] = val;
                        size_one++;
                    end else begin
                        size_two++;
                        words[STORE_DEPTH - size_two] = val;
                    end
                end
                OP_POP, OP_PEEK: begin
                    cnt = sel ? size_two : size_one;
                    if (cnt == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        idx = sel ? (STORE_DEPTH - size_two) : (size_one - 1);
                        r.read_value = words[idx];
                        if (op == OP_POP) begin
                            if (sel) size_two--;
                            else size_one--;
                        end
                    end
                end
                default: begin
                    if (sel) size_two = 0;
                    else size_one = 0;
                end
            endcase
            r.one_size = size_one[SIZE_W-1:0];
            r.two_size = size_two[SIZE_W-1:0];
            r.full     = (size_one + size_two >= STORE_DEPTH);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned act_v);
            if (exp_v !== act_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        // Compare one output transaction against the oldest prediction
        function void check_result(logic [M_TDATA_W-1:0] d);
            stack_result_t e;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, expected none actual %0h",
                         $time, d);
                return;
            end
            e = pending_results.pop_front();
            compare_field("read_value", e.read_value, d[31:0]);
            compare_field("status", e.status, d[33:32]);
            compare_field("stack_one_size", e.one_size, d[42:34]);
            compare_field("stack_two_size", e.two_size, d[51:43]);
            compare_field("store_full", e.full, d[52]);
            compare_field("pad", 0, d[M_TDATA_W-1:53]);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [31:0] push_value
    logic [S_TUSER_W-1:0]  s_tuser;   // [1:0] kind, [2] which_stack
    logic                  m_tvalid;
    logic                  m_tready;
    // [31:0] read_value, [33:32] status, [42:34] stack_one_size,
    // [51:43] stack_two_size, [52] store_full, [55:53] zero
    logic [M_TDATA_W-1:0]  m_tdata;

    stack_pair_scoreboard board;
    int                   ops_sent;
    int                   ops_total;
    bit                   quiet;       // set near the end: no more idling
    int                   cycle_count;

    shared_array_double_stack_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog: a hang anywhere ends the run as a failure
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output monitor. Sampling right after the edge sees the pre-edge values,
    // i.e. exactly what the block saw when the transaction happened.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
        end
    end

    // Receiver side: random stall bursts, one long hold once the run is going,
    // and a steady ready during the quiet tail. One m_tready update per edge.
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (!hold_done && ops_sent >= HOLD_AFTER) begin
                // sender keeps offering, block fills and drops s_tready
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Sender-side gap: drop tvalid for a random burst, never in the quiet tail
    task automatic sender_gap();
        if (!quiet && $urandom_range(9) < 3) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    // Offer one op and hold it until the handshake; tvalid stays high after
    // the accept so back-to-back ops never lower and raise it in one step.
    task automatic send_op(op_t op, bit sel, logic [VALUE_W-1:0] val);
        sender_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= {sel, op};
        do @(posedge aclk); while (!s_tready);
        board.note_op(op, sel, val);
        ops_sent++;
        if (ops_sent >= ops_total - QUIET_TAIL) quiet = 1'b1;
    endtask

    // One random stretch of ops with a given mix; clear takes what is left.
    // one_pct is the chance to pick stack one.
    task automatic run_mix(int n, int push_pct, int pop_pct, int peek_pct, int one_pct);
        int  roll;
        op_t op;
        bit  sel;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < push_pct)                          op = OP_PUSH;
            else if (roll < push_pct + pop_pct)           op = OP_POP;
            else if (roll < push_pct + pop_pct + peek_pct) op = OP_PEEK;
            else                                          op = OP_CLEAR;
            sel = ($urandom_range(99) < one_pct) ? 1'b0 : 1'b1;
            send_op(op, sel, $urandom);
        end
    endtask

    initial begin : main
        board     = new();
        ops_sent  = 0;
        ops_total = 23 + 330 + 300 + 330 + 200 + 200;
        quiet     = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-stack refusals, data extremes, peek vs pop on both
        // stacks, clear of one stack leaving the other alone, clear when empty
        send_op(OP_POP,   1'b0, 32'h0);
        send_op(OP_PEEK,  1'b0, 32'hFFFF_FFFF);
        send_op(OP_POP,   1'b1, 32'h0);
        send_op(OP_PEEK,  1'b1, 32'h0);
        send_op(OP_PUSH,  1'b0, 32'h0000_0000);
        send_op(OP_PUSH,  1'b0, 32'hFFFF_FFFF);
        send_op(OP_PUSH,  1'b1, 32'hFFFF_FFFF);
        send_op(OP_PUSH,  1'b1, 32'h0000_0000);
        send_op(OP_PUSH,  1'b1, 32'hA5A5_5A5A);
        send_op(OP_PEEK,  1'b0, 32'h0);
        send_op(OP_PEEK,  1'b1, 32'h0);
        send_op(OP_POP,   1'b0, 32'h0);
        send_op(OP_POP,   1'b1, 32'h0);
        send_op(OP_CLEAR, 1'b0, 32'h0);
        send_op(OP_POP,   1'b0, 32'h0);
        send_op(OP_PEEK,  1'b1, 32'h0);
        send_op(OP_CLEAR, 1'b1, 32'h0);
        send_op(OP_PEEK,  1'b1, 32'h0);
        send_op(OP_CLEAR, 1'b0, 32'h0);
        send_op(OP_PUSH,  1'b0, 32'h5555_5555);
        send_op(OP_PUSH,  1'b1, 32'hAAAA_AAAA);
        send_op(OP_POP,   1'b0, 32'h0);
        send_op(OP_POP,   1'b1, 32'h0);

        // Random: fill mostly through stack one until pushes bounce off full
        run_mix(330, 90, 4, 5, 90);
        // drain with pops/peeks and a few clears to empty both stacks
        run_mix(300, 10, 70, 15, 50);
        // fill mostly through stack two
        run_mix(330, 90, 4, 5, 10);
        // balanced churn with clears
        run_mix(200, 40, 30, 20, 50);
        // fill from both ends so the tops meet mid-store
        run_mix(200, 88, 5, 6, 50);

        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
